// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands for the rtl, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BMV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bmvt_pkg.sv =====
// ----------------------------------------------------------------------------
// bmvt_pkg
// types, constants and code points of the beam multiplicity veto trigger
// ----------------------------------------------------------------------------
package bmvt_pkg;

  localparam int NUM_SEGMENTS = 15;
  localparam int NUM_TILES    = 34;

  localparam int SEG_IDX_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int TILE_IDX_W = $clog2(NUM_TILES);
  localparam int MULT_CNT_W = $clog2(NUM_TILES + 1);

  localparam int SUM_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int SEG_CFG_W  = 4;
  localparam int MASK_W     = 34;
  localparam int MULT_W     = 6;

  // segment index against the beam range registers
  localparam int SEG_CFG_CMP_W = SEG_IDX_W + SEG_CFG_W;

  // segment geometry in 1/16 mm: pitch 224 = 7 * 32
  localparam int X_CENTER        = -160;
  localparam int SEG_PITCH       = 224;
  localparam int HALF_SPAN       = NUM_SEGMENTS * (SEG_PITCH / 2);
  localparam int FULL_SPAN       = 2 * HALF_SPAN;
  localparam int X_OFFSET        = HALF_SPAN - X_CENTER;
  localparam int SEG_SHIFT       = 5;
  localparam int SEG_RECIP       = 293;
  localparam int SEG_RECIP_SHIFT = 11;
  localparam int POS_W           = 18;
  localparam int SPAN_W          = $clog2(FULL_SPAN);
  localparam int COARSE_W        = SPAN_W - SEG_SHIFT;
  localparam int RECIP_W         = 9;
  localparam int PROD_W          = COARSE_W + RECIP_W;
  localparam int QUOT_W          = PROD_W - SEG_RECIP_SHIFT;

  // tiles of the adjacent-pair vetoes
  localparam int VETO_T19 = 19;
  localparam int VETO_T20 = 20;
  localparam int VETO_T21 = 21;
  localparam int VETO_T22 = 22;
  localparam int VETO_T23 = 23;
  localparam int VETO_T24 = 24;

  localparam logic [MASK_W-1:0] LOW_GROUP_A_MASK = MASK_W'(34'h0_0000_001E);
  localparam logic [MASK_W-1:0] LOW_GROUP_B_MASK = MASK_W'(34'h0_0000_003F);
  localparam logic [MASK_W-1:0] MULT_EXCL_RESET  = MASK_W'(34'h0_0000_001E);

  localparam logic [SEG_CFG_W-1:0] BEAM_SEG_LOW_RESET  = SEG_CFG_W'(4);
  localparam logic [SEG_CFG_W-1:0] BEAM_SEG_HIGH_RESET = SEG_CFG_W'(10);
  localparam logic [SUM_W-1:0]     BEAM_THR_RESET      = SUM_W'(100);
  localparam logic [SUM_W-1:0]     TILE_THR_RESET      = SUM_W'(200);

  typedef enum logic [1:0] {
    OP_BEAM_HIT  = 2'd0,
    OP_TILE_HIT  = 2'd1,
    OP_EVENT_END = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM_SEG_LOW  = 3'd0,
    CFG_BEAM_SEG_HIGH = 3'd1,
    CFG_BEAM_THR      = 3'd2,
    CFG_TILE_THR      = 3'd3,
    CFG_FULL_EXCL     = 3'd4,
    CFG_MULT_EXCL     = 3'd5
  } cfg_index_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] position_x;
    logic [5:0]         tile_id;
    logic [15:0]        hit_energy;
  } in_item_t;

  typedef struct packed {
    logic              beam_ok;
    logic [MULT_W-1:0] multiplicity;
    logic              trig_first;
    logic              trig_tight;
    logic              trig_fit;
    logic              trig_wide;
    logic              trig_ultra;
    logic              low_group_a;
    logic              low_group_b;
    logic [MASK_W-1:0] valid_tiles;
  } out_item_t;

endpackage

// ===== rtl/core/beam_multiplicity_veto_trigger_unit.sv =====
// ----------------------------------------------------------------------------
// beam_multiplicity_veto_trigger_unit
// per-event beam segment and tile energy sums, thresholds, multiplicity and
// adjacent-pair vetoes
// ----------------------------------------------------------------------------
// One hit or end-of-event transaction is taken every clock. A transaction is
// registered on entry and handled in the following cycle: hits add into the
// saturating per-channel sums, an end-of-event transaction thresholds all sums
// in parallel, loads the result register and clears the event; the result is
// held in the result register until the output side takes it. Only an
// end-of-event transaction can stall the input, and only while the result
// register still holds an earlier result that the output side has not taken.
// Configuration writes take effect at the next clock and must be made while no
// transaction is in flight; the masks and thresholds are sampled at event end.
`include "assert_macros.svh"

module beam_multiplicity_veto_trigger_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bmvt_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bmvt_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [bmvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmvt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration
  logic [bmvt_pkg::SEG_CFG_W-1:0] seg_low_r, seg_high_r;
  logic [bmvt_pkg::SUM_W-1:0]     beam_thr_r, tile_thr_r;
  logic [bmvt_pkg::MASK_W-1:0]    full_excl_r, mult_excl_r;

  // input register
  logic                 s1_valid_r;
  bmvt_pkg::in_item_t   s1_r;
  logic                 s1_adv;
  logic                 s1_is_end;
  logic                 out_free;

  // event sums
  logic [bmvt_pkg::SUM_W-1:0]        seg_sum_r  [bmvt_pkg::NUM_SEGMENTS];
  logic [bmvt_pkg::SUM_W-1:0]        tile_sum_r [bmvt_pkg::NUM_TILES];
  logic [bmvt_pkg::NUM_SEGMENTS-1:0] seg_seen_r;
  logic [bmvt_pkg::NUM_TILES-1:0]    tile_seen_r;

  // beam hit position to segment
  logic signed [bmvt_pkg::POS_W-1:0]  pos_u;
  logic                               seg_in_range;
  logic [bmvt_pkg::COARSE_W-1:0]      seg_coarse;
  logic [bmvt_pkg::PROD_W-1:0]        seg_prod;
  logic [bmvt_pkg::QUOT_W-1:0]        seg_quot;
  logic [bmvt_pkg::SEG_IDX_W-1:0]     seg_idx;
  logic [bmvt_pkg::SUM_W-1:0]         seg_base;
  logic [bmvt_pkg::SUM_W:0]           seg_add;
  logic [bmvt_pkg::SUM_W-1:0]         seg_sum_nxt;
  logic                               seg_wr;

  // tile hit
  logic                               tile_in_range;
  logic [bmvt_pkg::TILE_IDX_W-1:0]    tile_idx;
  logic [bmvt_pkg::SUM_W-1:0]         tile_base;
  logic [bmvt_pkg::SUM_W:0]           tile_add;
  logic [bmvt_pkg::SUM_W-1:0]         tile_sum_nxt;
  logic                               tile_wr;

  // event end
  logic                               beam_ok;
  logic [bmvt_pkg::NUM_TILES-1:0]     tile_over;
  logic [bmvt_pkg::MASK_W-1:0]        valid_tiles;
  logic [bmvt_pkg::MASK_W-1:0]        mult_tiles;
  logic [bmvt_pkg::MULT_CNT_W-1:0]    mult_cnt;
  logic [bmvt_pkg::MULT_W-1:0]        mult_sat;
  logic                               trig_first;
  logic                               pair_tight, pair_fit, pair_wide, pair_ultra;
  bmvt_pkg::out_item_t                result_nxt;

  // output register
  logic                 out_valid_r;
  bmvt_pkg::out_item_t  out_data_r;

  // handshake
  assign s1_is_end = (s1_r.opcode == bmvt_pkg::OP_EVENT_END);
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (!s1_is_end || out_free);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_low_r   <= bmvt_pkg::BEAM_SEG_LOW_RESET;
      seg_high_r  <= bmvt_pkg::BEAM_SEG_HIGH_RESET;
      beam_thr_r  <= bmvt_pkg::BEAM_THR_RESET;
      tile_thr_r  <= bmvt_pkg::TILE_THR_RESET;
      full_excl_r <= '0;
      mult_excl_r <= bmvt_pkg::MULT_EXCL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bmvt_pkg::CFG_BEAM_SEG_LOW:  seg_low_r   <= cfg_data[bmvt_pkg::SEG_CFG_W-1:0];
        bmvt_pkg::CFG_BEAM_SEG_HIGH: seg_high_r  <= cfg_data[bmvt_pkg::SEG_CFG_W-1:0];
        bmvt_pkg::CFG_BEAM_THR:      beam_thr_r  <= cfg_data[bmvt_pkg::SUM_W-1:0];
        bmvt_pkg::CFG_TILE_THR:      tile_thr_r  <= cfg_data[bmvt_pkg::SUM_W-1:0];
        bmvt_pkg::CFG_FULL_EXCL:     full_excl_r <= cfg_data[bmvt_pkg::MASK_W-1:0];
        bmvt_pkg::CFG_MULT_EXCL:     mult_excl_r <= cfg_data[bmvt_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
  end

  // beam hit: segment = (x - center + half span) / pitch
  always_comb begin
    pos_u = {{(bmvt_pkg::POS_W-16){s1_r.position_x[15]}}, s1_r.position_x}
            + bmvt_pkg::POS_W'(bmvt_pkg::X_OFFSET);
    seg_in_range = !pos_u[bmvt_pkg::POS_W-1]
                   && (pos_u < bmvt_pkg::POS_W'(bmvt_pkg::FULL_SPAN));
    seg_coarse   = pos_u[bmvt_pkg::SPAN_W-1:bmvt_pkg::SEG_SHIFT];
    seg_prod     = bmvt_pkg::PROD_W'(seg_coarse)
                   * bmvt_pkg::PROD_W'(bmvt_pkg::SEG_RECIP);
    seg_quot     = seg_prod[bmvt_pkg::PROD_W-1:bmvt_pkg::SEG_RECIP_SHIFT];
    if (seg_quot >= bmvt_pkg::QUOT_W'(bmvt_pkg::NUM_SEGMENTS)) begin
      seg_idx = bmvt_pkg::SEG_IDX_W'(bmvt_pkg::NUM_SEGMENTS - 1);
    end else begin
      seg_idx = seg_quot[bmvt_pkg::SEG_IDX_W-1:0];
    end
    seg_base    = seg_seen_r[seg_idx] ? seg_sum_r[seg_idx] : '0;
    seg_add     = {1'b0, seg_base} + (bmvt_pkg::SUM_W + 1)'(s1_r.hit_energy);
    seg_sum_nxt = seg_add[bmvt_pkg::SUM_W] ? bmvt_pkg::SUM_MAX
                                            : seg_add[bmvt_pkg::SUM_W-1:0];
    seg_wr      = s1_adv && (s1_r.opcode == bmvt_pkg::OP_BEAM_HIT) && seg_in_range;
  end

  // tile hit
  always_comb begin
    tile_in_range = ({1'b0, s1_r.tile_id} < 7'(bmvt_pkg::NUM_TILES));
    tile_idx      = bmvt_pkg::TILE_IDX_W'(s1_r.tile_id);
    tile_base     = tile_seen_r[tile_idx] ? tile_sum_r[tile_idx] : '0;
    tile_add      = {1'b0, tile_base} + (bmvt_pkg::SUM_W + 1)'(s1_r.hit_energy);
    tile_sum_nxt  = tile_add[bmvt_pkg::SUM_W] ? bmvt_pkg::SUM_MAX
                                               : tile_add[bmvt_pkg::SUM_W-1:0];
    tile_wr       = s1_adv && (s1_r.opcode == bmvt_pkg::OP_TILE_HIT) && tile_in_range;
  end

  // sums, with a seen bit standing for the per-event clear
  always_ff @(posedge clk) begin
    if (seg_wr) begin
      seg_sum_r[seg_idx] <= seg_sum_nxt;
    end
    if (tile_wr) begin
      tile_sum_r[tile_idx] <= tile_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_seen_r  <= '0;
      tile_seen_r <= '0;
    end else if (s1_adv && s1_is_end) begin
      seg_seen_r  <= '0;
      tile_seen_r <= '0;
    end else begin
      if (seg_wr) begin
        seg_seen_r[seg_idx] <= 1'b1;
      end
      if (tile_wr) begin
        tile_seen_r[tile_idx] <= 1'b1;
      end
    end
  end

  // event end evaluation
  always_comb begin
    beam_ok = 1'b0;
    for (int i = 0; i < bmvt_pkg::NUM_SEGMENTS; i++) begin
      if (seg_seen_r[i] && (seg_sum_r[i] >= beam_thr_r)
          && (bmvt_pkg::SEG_CFG_CMP_W'(i) >= bmvt_pkg::SEG_CFG_CMP_W'(seg_low_r))
          && (bmvt_pkg::SEG_CFG_CMP_W'(i) <= bmvt_pkg::SEG_CFG_CMP_W'(seg_high_r))) begin
        beam_ok = 1'b1;
      end
    end
    for (int i = 0; i < bmvt_pkg::NUM_TILES; i++) begin
      tile_over[i] = tile_seen_r[i] && (tile_sum_r[i] >= tile_thr_r);
    end
    valid_tiles = bmvt_pkg::MASK_W'(tile_over) & ~full_excl_r;
    mult_tiles  = valid_tiles & ~mult_excl_r;
    mult_cnt    = '0;
    for (int i = 0; i < bmvt_pkg::MASK_W; i++) begin
      mult_cnt = mult_cnt + bmvt_pkg::MULT_CNT_W'(mult_tiles[i]);
    end
    if (mult_cnt > bmvt_pkg::MULT_CNT_W'({bmvt_pkg::MULT_W{1'b1}})) begin
      mult_sat = {bmvt_pkg::MULT_W{1'b1}};
    end else begin
      mult_sat = bmvt_pkg::MULT_W'(mult_cnt);
    end
    trig_first = beam_ok && (mult_sat >= bmvt_pkg::MULT_W'(2));
    pair_tight = (valid_tiles[bmvt_pkg::VETO_T20] && valid_tiles[bmvt_pkg::VETO_T21])
                 || (valid_tiles[bmvt_pkg::VETO_T21] && valid_tiles[bmvt_pkg::VETO_T22]);
    pair_fit   = pair_tight
                 || (valid_tiles[bmvt_pkg::VETO_T22] && valid_tiles[bmvt_pkg::VETO_T23]);
    pair_wide  = pair_fit
                 || (valid_tiles[bmvt_pkg::VETO_T19] && valid_tiles[bmvt_pkg::VETO_T20]);
    pair_ultra = pair_wide
                 || (valid_tiles[bmvt_pkg::VETO_T23] && valid_tiles[bmvt_pkg::VETO_T24]);

    result_nxt.beam_ok      = beam_ok;
    result_nxt.multiplicity = mult_sat;
    result_nxt.trig_first   = trig_first;
    result_nxt.trig_tight   = trig_first && !pair_tight;
    result_nxt.trig_fit     = trig_first && !pair_fit;
    result_nxt.trig_wide    = trig_first && !pair_wide;
    result_nxt.trig_ultra   = trig_first && !pair_ultra;
    result_nxt.low_group_a  = trig_first && |(valid_tiles & bmvt_pkg::LOW_GROUP_A_MASK);
    result_nxt.low_group_b  = trig_first && |(valid_tiles & bmvt_pkg::LOW_GROUP_B_MASK);
    result_nxt.valid_tiles  = valid_tiles;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_is_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_is_end) begin
      out_data_r <= result_nxt;
    end
  end

  `BMV_ASSERT_NXT(a_event_clears, s1_adv && s1_is_end, (seg_seen_r == '0) && (tile_seen_r == '0), "sums not cleared after event end")
  `BMV_ASSERT_NXT(a_event_result, s1_adv && s1_is_end, out_valid_r, "event end gave no result")
  `BMV_ASSERT_IMP(a_veto_order, out_valid_r && out_data_r.trig_ultra, out_data_r.trig_wide && out_data_r.trig_fit && out_data_r.trig_tight, "veto levels not nested")
  `BMV_ASSERT_IMP(a_no_overwrite, out_valid_r && out_stall, !(s1_adv && s1_is_end), "held result overwritten")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for beam_multiplicity_veto_trigger_unit
// ----------------------------------------------------------------------------
// Drives hit and end-of-event transactions through the valid/stall input and
// checks every trigger result against an in-bench prediction of the segment
// and tile sums, thresholds, exclusion masks and pair vetoes. A short table of
// directed transactions comes first. Randomized events then run under several
// register settings and idle patterns, including a long output hold-off and a
// pause that waits for the output side to drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmvt_pkg::*;

  localparam int DIR_ROWS     = 24;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 156;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 6;
  localparam int DRAIN_LIMIT  = 20000;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam out_item_t NO_TRIGGER = '0;
  localparam logic [MASK_W-1:0] ALL_TILES = {MASK_W{1'b1}};

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted block state and register copies
  logic [SUM_W-1:0]        seg_energy [NUM_SEGMENTS] = '{default: '0};
  logic [SUM_W-1:0]        tile_energy [NUM_TILES] = '{default: '0};
  logic [NUM_SEGMENTS-1:0] seg_hit = '0;
  logic [NUM_TILES-1:0]    tile_hit = '0;
  logic [SEG_CFG_W-1:0]    seg_lo = BEAM_SEG_LOW_RESET;
  logic [SEG_CFG_W-1:0]    seg_hi = BEAM_SEG_HIGH_RESET;
  logic [SUM_W-1:0]        seg_thr = BEAM_THR_RESET;
  logic [SUM_W-1:0]        tile_thr = TILE_THR_RESET;
  logic [MASK_W-1:0]       full_excl = '0;
  logic [MASK_W-1:0]       mult_excl = MULT_EXCL_RESET;

  out_item_t pending_triggers [$];
  int        errors = 0;
  int        results_checked = 0;
  int        items_sent = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        hold_seq = 0;

  beam_multiplicity_veto_trigger_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [15:0] e);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + e;
    return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic out_item_t close_event();
    out_item_t         r;
    logic              beam, trig, vt, vf, vw, vu;
    logic [MASK_W-1:0] valid, mp;
    int                mult;
    beam  = 1'b0;
    valid = '0;
    for (int i = 0; i < NUM_SEGMENTS; i++)
      if (seg_hit[i] && seg_energy[i] >= seg_thr && i >= seg_lo && i <= seg_hi) beam = 1'b1;
    for (int i = 0; i < NUM_TILES; i++)
      if (tile_hit[i] && tile_energy[i] >= tile_thr) valid[i] = 1'b1;
    valid = valid & ~full_excl;
    mp    = valid & ~mult_excl;
    mult  = $countones(mp);
    if (mult > 63) mult = 63;
    trig = beam && mult >= 2;
    vt = (valid[VETO_T20] && valid[VETO_T21]) || (valid[VETO_T21] && valid[VETO_T22]);
    vf = vt || (valid[VETO_T22] && valid[VETO_T23]);
    vw = vf || (valid[VETO_T19] && valid[VETO_T20]);
    vu = vw || (valid[VETO_T23] && valid[VETO_T24]);
    r.beam_ok      = beam;
    r.multiplicity = MULT_W'(mult);
    r.trig_first   = trig;
    r.trig_tight   = trig && !vt;
    r.trig_fit     = trig && !vf;
    r.trig_wide    = trig && !vw;
    r.trig_ultra   = trig && !vu;
    r.low_group_a  = trig && |(valid & LOW_GROUP_A_MASK);
    r.low_group_b  = trig && |(valid & LOW_GROUP_B_MASK);
    r.valid_tiles  = valid;
    seg_energy  = '{default: '0};
    tile_energy = '{default: '0};
    seg_hit     = '0;
    tile_hit    = '0;
    return r;
  endfunction

  function automatic bit predict_transaction(input in_item_t it, output out_item_t res);
    int xl, seg;
    res = '0;
    case (it.opcode)
      OP_BEAM_HIT: begin
        xl = int'($signed(it.position_x)) - X_CENTER;
        if (xl >= -HALF_SPAN && xl < HALF_SPAN) begin
          seg = (xl + HALF_SPAN) / SEG_PITCH;
          if (seg >= NUM_SEGMENTS) seg = NUM_SEGMENTS - 1;
          seg_energy[seg] = sat_add(seg_energy[seg], it.hit_energy);
          seg_hit[seg]    = 1'b1;
        end
      end
      OP_TILE_HIT: begin
        if (it.tile_id < NUM_TILES) begin
          tile_energy[it.tile_id] = sat_add(tile_energy[it.tile_id], it.hit_energy);
          tile_hit[it.tile_id]    = 1'b1;
        end
      end
      OP_EVENT_END: begin
        res = close_event();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic in_item_t raw_item();
    logic [63:0] bits64;
    bits64 = {$urandom, $urandom};
    return bits64[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t event_end_item();
    in_item_t it;
    it = raw_item();
    it.opcode = OP_EVENT_END;
    return it;
  endfunction

  function automatic in_item_t hit_item(input bit focus);
    in_item_t it;
    it = raw_item();
    if ($urandom_range(99) < 40) begin
      it.opcode = OP_BEAM_HIT;
      if ($urandom_range(9) != 0)
        it.position_x = 16'(int'($urandom_range(0, FULL_SPAN - 1)) + X_CENTER - HALF_SPAN);
    end else begin
      it.opcode = OP_TILE_HIT;
      if ($urandom_range(9) != 0)
        it.tile_id = focus ? 6'($urandom_range(VETO_T19 - 1, VETO_T24 + 1))
                           : 6'($urandom_range(0, NUM_TILES - 1));
    end
    case ($urandom_range(3))
      0: it.hit_energy = 16'($urandom_range(0, 400));
      1: it.hit_energy = 16'hFFFF;
      default: ;
    endcase
    return it;
  endfunction

  function automatic dir_row_t dir_row(input logic [1:0] op, input int x, input int tile,
                                       input int e, input bit typed);
    dir_row_t r;
    r.item.opcode     = opcode_t'(op);
    r.item.position_x = 16'(x);
    r.item.tile_id    = 6'(tile);
    r.item.hit_energy = 16'(e);
    r.typed           = typed;
    r.result          = NO_TRIGGER;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_triggers.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      errors++;
    end else begin
      want = pending_triggers.pop_front();
      results_checked++;
      compare_field("beam_ok", want.beam_ok, got.beam_ok);
      compare_field("multiplicity", want.multiplicity, got.multiplicity);
      compare_field("trig_first", want.trig_first, got.trig_first);
      compare_field("trig_tight", want.trig_tight, got.trig_tight);
      compare_field("trig_fit", want.trig_fit, got.trig_fit);
      compare_field("trig_wide", want.trig_wide, got.trig_wide);
      compare_field("trig_ultra", want.trig_ultra, got.trig_ultra);
      compare_field("low_group_a", want.low_group_a, got.low_group_a);
      compare_field("low_group_b", want.low_group_b, got.low_group_b);
      compare_field("valid_tiles", want.valid_tiles, got.valid_tiles);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  initial begin : result_receiver
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != holds_served) begin
        holds_served = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic send_transaction(input in_item_t it, input bit typed,
                                  input out_item_t typed_res);
    out_item_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_transaction(it, res)) pending_triggers.push_back(typed ? typed_res : res);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_triggers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_triggers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_triggers.size());
      errors++;
      pending_triggers.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [SEG_CFG_W-1:0] lo, input logic [SEG_CFG_W-1:0] hi,
                           input logic [SUM_W-1:0] bthr, input logic [SUM_W-1:0] tthr,
                           input logic [MASK_W-1:0] fm, input logic [MASK_W-1:0] mm);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BEAM_SEG_LOW;  cfg_data <= CFG_DATA_W'(lo);   @(posedge clk);
    cfg_index <= CFG_BEAM_SEG_HIGH; cfg_data <= CFG_DATA_W'(hi);   @(posedge clk);
    cfg_index <= CFG_BEAM_THR;      cfg_data <= CFG_DATA_W'(bthr); @(posedge clk);
    cfg_index <= CFG_TILE_THR;      cfg_data <= CFG_DATA_W'(tthr); @(posedge clk);
    cfg_index <= CFG_FULL_EXCL;     cfg_data <= CFG_DATA_W'(fm);   @(posedge clk);
    cfg_index <= CFG_MULT_EXCL;     cfg_data <= CFG_DATA_W'(mm);   @(posedge clk);
    cfg_we <= 1'b0;
    seg_lo    = lo;
    seg_hi    = hi;
    seg_thr   = bthr;
    tile_thr  = tthr;
    full_excl = fm;
    mult_excl = mm;
  endtask

  task automatic run_events(input int n);
    int       stop_at, kind, hits;
    bit       held, paused, focus;
    in_item_t it;
    stop_at = items_sent + n;
    held    = 1'b0;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      if (!held && items_sent >= stop_at - 2 * n / 3) begin
        hold_seq++;
        held = 1'b1;
      end
      if (!paused && items_sent >= stop_at - n / 3) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_triggers.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 8) begin
        // noise: any opcode, any field values
        hits = $urandom_range(1, 4);
        repeat (hits) send_transaction(raw_item(), 1'b0, NO_TRIGGER);
      end else if (kind < 16) begin
        // pile-up of repeated full-scale hits on one channel can drive its sum into saturation
        it = hit_item(1'b0);
        it.hit_energy = 16'hFFFF;
        hits = $urandom_range(16, 20);
        repeat (hits) send_transaction(it, 1'b0, NO_TRIGGER);
        send_transaction(event_end_item(), 1'b0, NO_TRIGGER);
      end else begin
        hits  = $urandom_range(0, 14);
        focus = ($urandom_range(2) == 0);
        repeat (hits) send_transaction(hit_item(focus), 1'b0, NO_TRIGGER);
        if (kind >= 24) send_transaction(event_end_item(), 1'b0, NO_TRIGGER);
      end
    end
  endtask

  initial begin : stimulus
    dir_row_t directed [DIR_ROWS];
    directed[0]  = dir_row(OP_EVENT_END, 0, 0, 0, 1'b1);
    directed[1]  = dir_row(OP_BEAM_HIT, -32768, 0, 16'hFFFF, 1'b0);
    directed[2]  = dir_row(OP_BEAM_HIT, 32767, 0, 16'hFFFF, 1'b0);
    directed[3]  = dir_row(OP_BEAM_HIT, X_CENTER - HALF_SPAN - 1, 0, 16'hFFFF, 1'b0);
    directed[4]  = dir_row(OP_BEAM_HIT, X_CENTER + HALF_SPAN, 0, 16'hFFFF, 1'b0);
    directed[5]  = dir_row(OP_TILE_HIT, 0, NUM_TILES, 16'hFFFF, 1'b0);
    directed[6]  = dir_row(OP_TILE_HIT, 0, 63, 16'hFFFF, 1'b0);
    directed[7]  = dir_row(OP_SPARE, -1, 63, 16'hFFFF, 1'b0);
    directed[8]  = dir_row(OP_EVENT_END, -1, 63, 16'hFFFF, 1'b1);
    directed[9]  = dir_row(OP_BEAM_HIT, X_CENTER - HALF_SPAN, 0, 16'hFFFF, 1'b0);
    directed[10] = dir_row(OP_BEAM_HIT, X_CENTER + HALF_SPAN - 1, 0, 16'hFFFF, 1'b0);
    directed[11] = dir_row(OP_BEAM_HIT, X_CENTER, 0, 100, 1'b0);
    directed[12] = dir_row(OP_TILE_HIT, 0, 0, 16'hFFFF, 1'b0);
    directed[13] = dir_row(OP_TILE_HIT, 0, NUM_TILES - 1, 16'hFFFF, 1'b0);
    directed[14] = dir_row(OP_TILE_HIT, 0, VETO_T20, 200, 1'b0);
    directed[15] = dir_row(OP_TILE_HIT, 0, VETO_T21, 199, 1'b0);
    directed[16] = dir_row(OP_TILE_HIT, 0, 2, 16'hFFFF, 1'b0);
    directed[17] = dir_row(OP_TILE_HIT, 0, VETO_T21, 1, 1'b0);
    directed[18] = dir_row(OP_TILE_HIT, 0, VETO_T19, 0, 1'b0);
    directed[19] = dir_row(OP_EVENT_END, 0, 0, 0, 1'b0);
    directed[20] = dir_row(OP_TILE_HIT, 0, VETO_T23, 16'hFFFF, 1'b0);
    directed[21] = dir_row(OP_TILE_HIT, 0, VETO_T24, 16'hFFFF, 1'b0);
    directed[22] = dir_row(OP_BEAM_HIT, 0, 0, 0, 1'b0);
    directed[23] = dir_row(OP_EVENT_END, 0, 0, 0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_transaction(directed[i].item, directed[i].typed, directed[i].result);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: configure('0, 4'(NUM_SEGMENTS - 1), '0, '0, '0, '0);
          2: configure(4'(NUM_SEGMENTS - 1), '0, SUM_MAX, SUM_MAX, '0, '0);
          3: configure('0, '0, SUM_W'(1), SUM_W'(1), ALL_TILES, ALL_TILES);
          default: configure(4'($urandom_range(0, NUM_SEGMENTS - 1)),
                             4'($urandom_range(0, NUM_SEGMENTS - 1)),
                             SUM_W'($urandom_range(0, 2000)),
                             SUM_W'($urandom_range(0, 2000)),
                             MASK_W'({$urandom, $urandom} & {$urandom, $urandom}),
                             MASK_W'({$urandom, $urandom} & {$urandom, $urandom}));
        endcase
      end
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
      endcase
      run_events((p == 0) ? PHASE_ITEMS - DIR_ROWS : PHASE_ITEMS);
    end

    settle();
    $display("sent %0d transactions, checked %0d trigger results", items_sent,
             results_checked);
    $display("%0d register settings, each with an output hold-off and a drain pause",
             NUM_PHASES);
    if (errors == 0) begin
      $display("[beam_multiplicity_veto_trigger_unit] OK");
    end else begin
      $display("[beam_multiplicity_veto_trigger_unit] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("%0t: timeout", $time);
    $display("[beam_multiplicity_veto_trigger_unit] ERROR");
    $finish;
  end

endmodule
